### hw/rtl/hkrm_pkg.sv
// Shared types, constants and bit-count helpers for the Hamming 2-NN ratio matcher.
package hkrm_pkg;

  // Default sizing of the descriptor database.
  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_DESC_WORDS  = 8;

  // Fixed field widths.
  localparam int WORD_W     = 64;
  localparam int CLASS_W    = 11;
  localparam int DIST_OUT_W = 10;
  localparam int ENTRY_W    = 10;
  localparam int WIDX_W     = 3;
  localparam int PIX_W      = 16;
  localparam int LANE_CW    = 7;
  localparam int THR_W      = 10;
  localparam int RATIO_W    = 9;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

  // Configuration reset values.
  localparam logic [THR_W-1:0]   RST_DIST_THR    = 10'd128;
  localparam logic [RATIO_W-1:0] RST_RATIO_THR   = 9'd205;
  localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT = 11'd1024;

  // Input beat opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_MATCH      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BACKGROUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_FAR    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_AMBIGUOUS  = 2'd3;

  // Class label that marks background entries (-1).
  localparam logic [CLASS_W-1:0] CLASS_BG = 11'h7FF;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } seq_state_t;

  // Control from the sequencer and the distance unit to the ranking unit.
  typedef struct packed {
    logic clear;
    logic step;
  } rank_ctl_t;

  // Status of the distance pipeline.
  typedef struct packed {
    logic busy;
    logic valid;
  } dist_stat_t;

  // Number of ones in a byte.
  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

  // Number of ones in a 64-bit word, as a sum of eight byte counts.
  function automatic logic [LANE_CW-1:0] popcnt64(input logic [WORD_W-1:0] v);
    logic [LANE_CW-1:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + LANE_CW'(popcnt8(v[8*k +: 8]));
    end
    return n;
  endfunction

endpackage

### hw/rtl/hkrm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hkrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/hkrm_dist_unit.sv
// Distance unit: XOR, per-word bit count and lane sum over two pipeline stages.
module hkrm_dist_unit
  import hkrm_pkg::*;
#(
  parameter int DESC_WORDS = DEF_DESC_WORDS,
  parameter int DIST_W     = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_valid,
  input  logic [DESC_WORDS-1:0][WORD_W-1:0]   query,
  input  logic [DESC_WORDS-1:0][WORD_W-1:0]   entry,
  input  logic [CLASS_W-1:0]                  entry_cls,
  output dist_stat_t                          stat,
  output logic [DIST_W-1:0]                   ham_dist,
  output logic [CLASS_W-1:0]                  dist_cls
);

  logic [DESC_WORDS-1:0][LANE_CW-1:0] lane_cnt_r;
  logic [CLASS_W-1:0]                 cls_a_r;
  logic                               va_r;
  logic [DIST_W-1:0]                  dist_r;
  logic [DIST_W-1:0]                  dist_nxt;
  logic [CLASS_W-1:0]                 cls_b_r;
  logic                               vb_r;

  // Stage A: bit count of each lane's XOR.
  always_ff @(posedge clk) begin
    for (int l = 0; l < DESC_WORDS; l++) begin
      lane_cnt_r[l] <= popcnt64(query[l] ^ entry[l]);
    end
    cls_a_r <= entry_cls;
  end

  // Stage B: sum of the lane counts.
  always_comb begin
    dist_nxt = '0;
    for (int l = 0; l < DESC_WORDS; l++) begin
      dist_nxt = dist_nxt + DIST_W'(lane_cnt_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    cls_b_r <= cls_a_r;
  end

  // Valid flags follow the data through both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= rd_valid;
      vb_r <= va_r;
    end
  end

  assign stat.valid = vb_r;
  assign stat.busy  = rd_valid | va_r | vb_r;
  assign ham_dist   = dist_r;
  assign dist_cls   = cls_b_r;

endmodule

### hw/rtl/hkrm_rank.sv
// Ranking unit: keeps the two smallest distances and grades the best match.
module hkrm_rank
  import hkrm_pkg::*;
#(
  parameter int DESC_WORDS = DEF_DESC_WORDS,
  parameter int DIST_W     = 10
) (
  input  logic                 clk,
  input  rank_ctl_t            ctl,
  input  logic [DIST_W-1:0]    ham_dist,
  input  logic [CLASS_W-1:0]   dist_cls,
  input  logic [THR_W-1:0]     dist_thr,
  input  logic [RATIO_W-1:0]   ratio_thr,
  output logic [DIST_W-1:0]    best,
  output logic [DIST_W-1:0]    second,
  output logic [CLASS_W-1:0]   best_cls,
  output logic [STATUS_W-1:0]  status
);

  localparam int DESC_BITS = DESC_WORDS * WORD_W;
  localparam int CMP_W     = (DIST_W > THR_W) ? DIST_W : THR_W;
  localparam int PROD_W    = DIST_W + RATIO_W;

  logic [DIST_W-1:0]  best_r;
  logic [DIST_W-1:0]  second_r;
  logic [CLASS_W-1:0] best_cls_r;
  logic [PROD_W-1:0]  lhs;
  logic [PROD_W-1:0]  rhs;

  // Running best and second best; ties keep the earlier entry.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_r   <= DIST_W'(DESC_BITS + 1);
      second_r <= DIST_W'(DESC_BITS);
    end else if (ctl.step) begin
      if (ham_dist < best_r) begin
        if (best_r <= DIST_W'(DESC_BITS)) begin
          second_r <= best_r;
        end
        best_r     <= ham_dist;
        best_cls_r <= dist_cls;
      end else if (ham_dist < second_r) begin
        second_r <= ham_dist;
      end
    end
  end

  // Ratio test: best * 256 against ratio * second.
  assign lhs = PROD_W'({best_r, 8'd0});
  assign rhs = PROD_W'(ratio_thr) * PROD_W'(second_r);

  // Grading: background first, then distance, then ratio.
  always_comb begin
    if (best_cls_r == CLASS_BG) begin
      status = STAT_BACKGROUND;
    end else if (CMP_W'(best_r) > CMP_W'(dist_thr)) begin
      status = STAT_TOO_FAR;
    end else if (lhs > rhs) begin
      status = STAT_AMBIGUOUS;
    end else begin
      status = STAT_MATCH;
    end
  end

  assign best     = best_r;
  assign second   = second_r;
  assign best_cls = best_cls_r;

endmodule

### hw/rtl/hamming_knn_ratio_matcher_core.sv
// Top level of the Hamming 2-NN ratio matcher: stores, sequencer and result register.
// Load beats and query beats other than the last word leave the sequencer idle.
// The last query word starts a scan of N = clamp(entry_count, 1, MAX_ENTRIES) entries,
// one entry per cycle through the lane RAMs and the distance unit; out_tvalid rises once
// the pipeline has drained and the output is free; in_tready stays low until then.
// rst_n is synchronous and active low; it clears the sequencer, the valid flags and the
// configuration registers. Descriptor and class stores are not cleared.
module hamming_knn_ratio_matcher_core
  import hkrm_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int DESC_WORDS  = DEF_DESC_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: entry_index, word_index, desc_word, entry_class, point_x, point_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode
  input  logic                  in_tuser,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: match_class, out_x, out_y, best_distance, second_distance, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status
  output logic [STATUS_W-1:0]   out_tuser,
  // Configuration port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW        = $clog2(MAX_ENTRIES);
  localparam int CW        = $clog2(MAX_ENTRIES + 1);
  localparam int DIST_W    = $clog2(DESC_WORDS * WORD_W + 2);

  // Input beat fields.
  logic [ENTRY_W-1:0]  f_entry;
  logic [WIDX_W-1:0]   f_widx;
  logic [WORD_W-1:0]   f_word;
  logic [CLASS_W-1:0]  f_cls;
  logic [PIX_W-1:0]    f_px;
  logic [PIX_W-1:0]    f_py;

  assign f_entry = in_tdata[9:0];
  assign f_widx  = in_tdata[12:10];
  assign f_word  = in_tdata[76:13];
  assign f_cls   = in_tdata[87:77];
  assign f_px    = in_tdata[103:88];
  assign f_py    = in_tdata[119:104];

  // Configuration registers.
  logic [THR_W-1:0]   dist_thr_r;
  logic [RATIO_W-1:0] ratio_thr_r;
  logic [COUNT_W-1:0] entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_thr_r    <= RST_DIST_THR;
      ratio_thr_r   <= RST_RATIO_THR;
      entry_count_r <= RST_ENTRY_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST_THR:    dist_thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_RATIO_THR:   ratio_thr_r   <= cfg_wdata[RATIO_W-1:0];
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Beat decode.
  logic accept, widx_ok, load_we, query_we, start;

  assign accept   = in_tvalid && in_tready;
  assign widx_ok  = 32'(f_widx) < DESC_WORDS;
  assign load_we  = accept && (in_tuser == OP_LOAD) && widx_ok && (32'(f_entry) < MAX_ENTRIES);
  assign query_we = accept && (in_tuser == OP_QUERY) && widx_ok;
  assign start    = query_we && (32'(f_widx) == DESC_WORDS - 1);

  // Effective scan length, clamped to one through MAX_ENTRIES.
  logic [CW-1:0] count_eff;

  always_comb begin
    if (entry_count_r == '0) begin
      count_eff = CW'(1);
    end else if (32'(entry_count_r) > MAX_ENTRIES) begin
      count_eff = CW'(MAX_ENTRIES);
    end else begin
      count_eff = CW'(entry_count_r);
    end
  end

  // Query buffer and keypoint of the last word.
  logic [DESC_WORDS-1:0][WORD_W-1:0] qbuf_r;
  logic [PIX_W-1:0]                  px_r;
  logic [PIX_W-1:0]                  py_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < DESC_WORDS; l++) begin
      if (query_we && (32'(f_widx) == l)) begin
        qbuf_r[l] <= f_word;
      end
    end
    if (start) begin
      px_r <= f_px;
      py_r <= f_py;
    end
  end

  // Sequencer.
  seq_state_t  state_r, state_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] count_r;
  logic          rd_en;
  logic          rd_valid_r;
  logic          out_free;
  logic          out_load;
  dist_stat_t    dstat;

  assign out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count_r <= count_eff;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx_r + CW'(1) == count_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!dstat.busy && out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // Descriptor lanes, one RAM per word, and the class store.
  logic [DESC_WORDS-1:0][WORD_W-1:0] lane_rdata;
  logic [CLASS_W-1:0]                cls_rdata;
  logic [AW-1:0]                     waddr;
  logic [AW-1:0]                     raddr;

  assign waddr = AW'(f_entry);
  assign raddr = scan_idx_r[AW-1:0];

  for (genvar l = 0; l < DESC_WORDS; l++) begin : g_lane
    hkrm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
    ) u_lane_ram (
      .clk   (clk),
      .we    (load_we && (32'(f_widx) == l)),
      .waddr (waddr),
      .wdata (f_word),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (lane_rdata[l])
    );
  end

  hkrm_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (MAX_ENTRIES)
  ) u_class_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (f_cls),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (cls_rdata)
  );

  // Distance pipeline.
  logic [DIST_W-1:0]  ham_dist;
  logic [CLASS_W-1:0] dist_cls;

  hkrm_dist_unit #(
    .DESC_WORDS (DESC_WORDS),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid_r),
    .query     (qbuf_r),
    .entry     (lane_rdata),
    .entry_cls (cls_rdata),
    .stat      (dstat),
    .ham_dist  (ham_dist),
    .dist_cls  (dist_cls)
  );

  // Two-nearest tracking and grading.
  rank_ctl_t          rctl;
  logic [DIST_W-1:0]  best;
  logic [DIST_W-1:0]  second;
  logic [CLASS_W-1:0] best_cls;
  logic [STATUS_W-1:0] status;

  assign rctl.clear = start;
  assign rctl.step  = dstat.valid;

  hkrm_rank #(
    .DESC_WORDS (DESC_WORDS),
    .DIST_W     (DIST_W)
  ) u_rank (
    .clk       (clk),
    .ctl       (rctl),
    .ham_dist  (ham_dist),
    .dist_cls  (dist_cls),
    .dist_thr  (dist_thr_r),
    .ratio_thr (ratio_thr_r),
    .best      (best),
    .second    (second),
    .best_cls  (best_cls),
    .status    (status)
  );

  // Result register.
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]   out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tuser_r <= status;
      out_tdata_r <= {1'b0, DIST_OUT_W'(second), DIST_OUT_W'(best), py_r, px_r, best_cls};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The distance pipeline is empty whenever the sequencer is idle.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !dstat.busy)
    else $error("distance pipeline busy while idle");

  // The scan address stays below the latched entry count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r < count_r))
    else $error("scan index beyond entry count");

  // A graded result never has its best distance above the second.
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (best <= second))
    else $error("best distance above second distance");

  // A matched result never names the background class.
  a_match_not_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r == STAT_MATCH)) |-> (out_tdata_r[10:0] != CLASS_BG))
    else $error("match reported on background class");

endmodule
